@@ sv/tcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg: shared types, constants and functions of the telegram CRC checker
// Holds the frame phase encoding, the result word layout, the CRC-16 byte
// fold and the hex digit decoder.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int unsigned CRC_W      = 16;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned NIBBLE_W   = 4;
	localparam int unsigned CRC_DIGITS = CRC_W / NIBBLE_W;
	localparam int unsigned CNT_W      = $clog2(CRC_DIGITS);

	localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
	localparam logic [CRC_W-1:0]  CRC_INIT = 16'h0000;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;

	localparam int unsigned OUT_PAYLOAD_W = 1 + 2 * CRC_W;
	localparam int unsigned OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;

	// Frame phase, one-hot coded.
	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_FRAME = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	typedef struct packed {
		logic [CRC_W-1:0] received_crc;
		logic [CRC_W-1:0] computed_crc;
		logic             crc_ok;
	} result_t;

	// Reflected CRC-16 update by one byte, eight bit steps unrolled.
	function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Decodes a hex digit in either case; bit 4 set means the byte is not hex.
	function automatic logic [NIBBLE_W:0] hex_value(input logic [BYTE_W-1:0] b);
		logic [NIBBLE_W:0] v;
		v = {1'b1, {NIBBLE_W{1'b0}}};
		if (b inside {[8'h30:8'h39]}) begin
			v = {1'b0, NIBBLE_W'(b - 8'h30)};
		end else if (b inside {[8'h41:8'h46]}) begin
			v = {1'b0, NIBBLE_W'(b - 8'h37)};
		end else if (b inside {[8'h61:8'h66]}) begin
			v = {1'b0, NIBBLE_W'(b - 8'h57)};
		end
		return v;
	endfunction

endpackage
`default_nettype wire

@@ sv/tcc_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_frame: telegram framing and checksum state
// Tracks the frame phase, folds frame bytes into the CRC and collects the
// hex checksum digits; flags a result when a check ends.
// ----------------------------------------------------------------------------
module tcc_frame (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       byte_valid,
	input  wire [tcc_pkg::BYTE_W-1:0] data_byte,
	output logic                      res_valid,
	output tcc_pkg::result_t          res
);
	import tcc_pkg::*;

	phase_t            phase_q,  phase_d;
	logic [CRC_W-1:0]  crc_q,    crc_d;
	logic [CNT_W-1:0]  count_q,  count_d;
	logic [CRC_W-1:0]  parsed_q, parsed_d;
	logic [NIBBLE_W:0] hex;
	logic [CRC_W-1:0]  parsed_next;
	logic [CRC_W-1:0]  crc_start;

	assign hex         = hex_value(data_byte);
	assign parsed_next = {parsed_q[CRC_W-NIBBLE_W-1:0], hex[NIBBLE_W-1:0]};
	assign crc_start   = fold_byte(CRC_INIT, CH_SLASH);

	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		count_d   = count_q;
		parsed_d  = parsed_q;
		res_valid = 1'b0;
		res       = '{received_crc: parsed_q, computed_crc: crc_q,
				crc_ok: (parsed_q == crc_q)};
		if (byte_valid) begin
			case (phase_q)
				PH_DIGIT: begin
					if (!hex[NIBBLE_W]) begin
						if (count_q == CNT_W'(CRC_DIGITS - 1)) begin
							res_valid = 1'b1;
							res       = '{received_crc: parsed_next, computed_crc: crc_q,
									crc_ok: (parsed_next == crc_q)};
							phase_d   = PH_IDLE;
							crc_d     = CRC_INIT;
							count_d   = '0;
							parsed_d  = '0;
						end else begin
							count_d  = count_q + 1'b1;
							parsed_d = parsed_next;
						end
					end else begin
						// A non-hex byte ends the check early, then counts as idle input.
						res_valid = 1'b1;
						count_d   = '0;
						parsed_d  = '0;
						if (data_byte == CH_SLASH) begin
							phase_d = PH_FRAME;
							crc_d   = crc_start;
						end else begin
							phase_d = PH_IDLE;
							crc_d   = CRC_INIT;
						end
					end
				end
				PH_FRAME: begin
					if (data_byte == CH_SLASH) begin
						crc_d = crc_start;
					end else begin
						crc_d = fold_byte(crc_q, data_byte);
						if (data_byte == CH_BANG) begin
							phase_d  = PH_DIGIT;
							count_d  = '0;
							parsed_d = '0;
						end
					end
				end
				default: begin
					if (data_byte == CH_SLASH) begin
						phase_d = PH_FRAME;
						crc_d   = crc_start;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			crc_q    <= CRC_INIT;
			count_q  <= '0;
			parsed_q <= '0;
		end else begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			count_q  <= count_d;
			parsed_q <= parsed_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/telegram_crc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// telegram_crc_checker: CRC-16 check of smart-meter P1 telegrams
// Byte-stream checker that compares the computed telegram CRC with the hex
// checksum that follows the exclamation mark.
// ----------------------------------------------------------------------------
// The block takes one telegram byte per word on the slave stream and gives
// one result word per completed check on the master stream. A slash starts
// (or restarts) a frame and clears the CRC-16 (reflected polynomial 0xA001,
// initial value zero, no final XOR); every byte from the slash through the
// exclamation mark is folded into it. The next up to four hex digits, in
// either case, form the received checksum; the check ends on the fourth
// digit, or earlier on any non-hex byte, in which case the digits seen so
// far count (zero if none) and that byte is then treated as idle input, so a
// slash there opens a new frame. Bytes outside a frame are dropped silently.
// The block accepts one byte every cycle unless stalled: the eight CRC bit
// steps of a byte are unrolled into combinational XOR logic, which sets the
// clock limit. A byte passes an input register, then the frame logic, into
// the result register. Both sides stall only when the result register is
// full and the master side holds tready low.
// ----------------------------------------------------------------------------
module telegram_crc_checker (
	input  wire                                clk,
	input  wire                                arst_n,
	// Slave stream, tdata: data_byte[7:0].
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire  [7:0]                         s_axis_tdata,
	// Master stream, tdata: crc_ok[0], computed_crc[16:1], received_crc[32:17],
	// zero fill[39:33].
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	output logic [tcc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import tcc_pkg::*;

	// Input register stage.
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;

	// Result register.
	logic              out_valid_q;
	result_t           out_q;

	logic              advance;
	logic              res_valid;
	result_t           res;

	// The frame stage moves whenever the result register is free or drains.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
		end
	end

	tcc_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (valid_s1 && advance),
		.data_byte  (data_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_PAYLOAD_W){1'b0}}, out_q};

endmodule
`default_nettype wire

@@ sv/tcc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_checker: port-level checks of the telegram CRC checker
// Watches the stream ports and flags inconsistent result words or stalls.
// ----------------------------------------------------------------------------
module tcc_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_axis_tvalid,
	input wire                             s_axis_tready,
	input wire                             m_axis_tvalid,
	input wire                             m_axis_tready,
	input wire [tcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import tcc_pkg::*;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// The match flag agrees with the two checksums in the same word.
	a_ok_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[16:1] == m_axis_tdata[32:17])))
		else $error("crc_ok disagrees with the checksums");

	// A new result word follows a byte accepted through the input register.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result word without a causing byte");

	// With the result register empty, the input side never stalls.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with no pending result");

	// The byte fill above the payload stays zero.
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:OUT_PAYLOAD_W] == '0))
		else $error("nonzero fill bits in result word");

endmodule

bind telegram_crc_checker tcc_checker u_tcc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
